/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked during reset.
`define ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/emb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package emb_pkg;

   // Internal word width for vector components and Q.30 angles.
   localparam int CW = 36;
   localparam int TABLE_LEN = 24;
   localparam int VEC_SHIFT = 14;
   localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0] ROUND_HALF = 36'sd65536;
   localparam logic signed [CW-1:0] ORIGIN_LIM = 36'sd16384;

   localparam logic signed [CW-1:0] ATAN_Q30 [TABLE_LEN] = '{
      36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
      36'sd67021686, 36'sd33543515, 36'sd16775850, 36'sd8388437,
      36'sd4194282, 36'sd2097149, 36'sd1048575, 36'sd524287,
      36'sd262143, 36'sd131071, 36'sd65535, 36'sd32767,
      36'sd16383, 36'sd8191, 36'sd4095, 36'sd2047,
      36'sd1023, 36'sd511, 36'sd255, 36'sd127
   };

   typedef struct packed {
      logic signed [15:0] left_angle;
      logic signed [15:0] right_angle;
      logic [15:0]        left_range;
      logic [15:0]        right_range;
   } req_type;

   typedef struct packed {
      logic signed [15:0] midpoint_angle;
      logic               degenerate;
   } rsp_type;

   // One word in the polar-to-Cartesian chain: both edges side by side.
   typedef struct packed {
      logic               valid;
      logic signed [CW-1:0] lx;
      logic signed [CW-1:0] ly;
      logic signed [CW-1:0] lz;
      logic signed [CW-1:0] rx;
      logic signed [CW-1:0] ry;
      logic signed [CW-1:0] rz;
      logic signed [15:0] left_angle;
      logic               coincide;
   } rot_type;

   // One word in the direction-finding chain.
   typedef struct packed {
      logic               valid;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic signed [15:0] left_angle;
      logic               degenerate;
   } vec_type;

endpackage
`default_nettype wire

/* hdl/edge_midpoint_bearing_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Word      Handshake
// req_     in         req_type  req_valid / req_stall
// rsp_     out        rsp_type  rsp_valid / rsp_stall
//
// One word is accepted every cycle while no stalled result is held. A word
// passes the entry, rotation cell, sum, vectoring cell and output registers.
// Reset clears the valid bits of every stage; payload registers are not reset.
// A stalled result freezes the whole chain, and req_stall follows rsp_stall
// while a result is held.
module edge_midpoint_bearing_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire emb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output emb_pkg::rsp_type      rsp_data
);
   import emb_pkg::*;

   logic advance;
   rot_type rot_chain [CORDIC_STEPS+1];
   vec_type vec_chain [CORDIC_STEPS+1];
   rot_type entry_ff, entry_in;
   vec_type sum_ff, sum_in;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic signed [CW-1:0] la_q30, ra_q30, sx, sy, zr;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Entry: angle to Q.30, fold angles beyond a quarter turn.
   always_comb begin
      la_q30 = CW'(req_data.left_angle) <<< 17;
      ra_q30 = CW'(req_data.right_angle) <<< 17;
      entry_in.valid = req_valid;
      entry_in.left_angle = req_data.left_angle;
      entry_in.coincide = (req_data.left_range == req_data.right_range) &&
                          (req_data.left_angle == req_data.right_angle);
      entry_in.ly = '0;
      entry_in.ry = '0;
      entry_in.lx = CW'({1'b0, req_data.left_range}) <<< VEC_SHIFT;
      entry_in.rx = CW'({1'b0, req_data.right_range}) <<< VEC_SHIFT;
      entry_in.lz = la_q30;
      entry_in.rz = ra_q30;
      if (la_q30 > HALF_PI_Q30) begin
         entry_in.lz = la_q30 - PI_Q30;
         entry_in.lx = -entry_in.lx;
      end else if (la_q30 < -HALF_PI_Q30) begin
         entry_in.lz = la_q30 + PI_Q30;
         entry_in.lx = -entry_in.lx;
      end
      if (ra_q30 > HALF_PI_Q30) begin
         entry_in.rz = ra_q30 - PI_Q30;
         entry_in.rx = -entry_in.rx;
      end else if (ra_q30 < -HALF_PI_Q30) begin
         entry_in.rz = ra_q30 + PI_Q30;
         entry_in.rx = -entry_in.rx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign rot_chain[0] = entry_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
      emb_rot_cell #(.STEP(g)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .cell_in(rot_chain[g]), .cell_out(rot_chain[g+1])
      );
   end

   // Sum of both edge vectors, coincidence and origin test, and half-plane fold.
   always_comb begin
      sx = rot_chain[CORDIC_STEPS].lx + rot_chain[CORDIC_STEPS].rx;
      sy = rot_chain[CORDIC_STEPS].ly + rot_chain[CORDIC_STEPS].ry;
      sum_in.valid = rot_chain[CORDIC_STEPS].valid;
      sum_in.left_angle = rot_chain[CORDIC_STEPS].left_angle;
      sum_in.degenerate = rot_chain[CORDIC_STEPS].coincide ||
         (sx < ORIGIN_LIM && sx > -ORIGIN_LIM && sy < ORIGIN_LIM && sy > -ORIGIN_LIM);
      sum_in.x = sx;
      sum_in.y = sy;
      sum_in.z = '0;
      if (sx < 0) begin
         sum_in.z = (sy >= 0) ? PI_Q30 : -PI_Q30;
         sum_in.x = -sx;
         sum_in.y = -sy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.valid <= 1'b0;
      end else if (advance) begin
         sum_ff <= sum_in;
      end
   end

   assign vec_chain[0] = sum_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
      emb_vec_cell #(.STEP(g)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .cell_in(vec_chain[g]), .cell_out(vec_chain[g+1])
      );
   end

   always_comb begin
      zr = (vec_chain[CORDIC_STEPS].z + ROUND_HALF) >>> 17;
      rsp_in.degenerate = vec_chain[CORDIC_STEPS].degenerate;
      rsp_in.midpoint_angle = vec_chain[CORDIC_STEPS].degenerate ?
         vec_chain[CORDIC_STEPS].left_angle : zr[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vec_chain[CORDIC_STEPS].valid;
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

/* hdl/emb_rot_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module emb_rot_cell #(
   parameter int STEP = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire emb_pkg::rot_type cell_in,
   output emb_pkg::rot_type      cell_out
);
   import emb_pkg::*;

   rot_type word_ff, word_in;

   always_comb begin
      word_in = cell_in;
      if (cell_in.lz >= 0) begin
         word_in.lx = cell_in.lx - (cell_in.ly >>> STEP);
         word_in.ly = cell_in.ly + (cell_in.lx >>> STEP);
         word_in.lz = cell_in.lz - ATAN_Q30[STEP];
      end else begin
         word_in.lx = cell_in.lx + (cell_in.ly >>> STEP);
         word_in.ly = cell_in.ly - (cell_in.lx >>> STEP);
         word_in.lz = cell_in.lz + ATAN_Q30[STEP];
      end
      if (cell_in.rz >= 0) begin
         word_in.rx = cell_in.rx - (cell_in.ry >>> STEP);
         word_in.ry = cell_in.ry + (cell_in.rx >>> STEP);
         word_in.rz = cell_in.rz - ATAN_Q30[STEP];
      end else begin
         word_in.rx = cell_in.rx + (cell_in.ry >>> STEP);
         word_in.ry = cell_in.ry - (cell_in.rx >>> STEP);
         word_in.rz = cell_in.rz + ATAN_Q30[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
      end
   end

   assign cell_out = word_ff;
endmodule
`default_nettype wire

/* hdl/emb_vec_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module emb_vec_cell #(
   parameter int STEP = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire emb_pkg::vec_type cell_in,
   output emb_pkg::vec_type      cell_out
);
   import emb_pkg::*;

   vec_type word_ff, word_in;

   always_comb begin
      word_in = cell_in;
      if (cell_in.y > 0) begin
         word_in.x = cell_in.x + (cell_in.y >>> STEP);
         word_in.y = cell_in.y - (cell_in.x >>> STEP);
         word_in.z = cell_in.z + ATAN_Q30[STEP];
      end else begin
         word_in.x = cell_in.x - (cell_in.y >>> STEP);
         word_in.y = cell_in.y + (cell_in.x >>> STEP);
         word_in.z = cell_in.z - ATAN_Q30[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
      end
   end

   assign cell_out = word_ff;
endmodule
`default_nettype wire

/* hdl/emb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module emb_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire emb_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire emb_pkg::rsp_type rsp_data
);
   import emb_pkg::*;

   logic held;
   logic req_fire;

   assign held = rsp_valid && rsp_stall;
   assign req_fire = req_valid && !req_stall;

   // The input side is held back exactly while a result waits.
   `ASSERT_IMPL(a_stall_link, clock, reset, 1'b1, req_stall == held, "req_stall not tied to held word")
   `ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result shown right after reset")
   `ASSERT_IMPL(a_rsp_hold, clock, reset, held, ##1 (rsp_valid && $stable(rsp_data)), "held word changed")
   // An accepted input word carries no unknown bits.
   `ASSERT_IMPL(a_req_known, clock, reset, req_fire, !$isunknown(req_data), "accepted word has X bits")
endmodule

bind edge_midpoint_bearing_top emb_checker u_emb_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
   import emb_pkg::*;

   localparam int STEPS = 16;
   localparam int LATENCY = 2 * STEPS + 3;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_WORDS = 600;
   localparam longint PI_FIX = 64'sd3373259426;
   localparam longint HALF_PI_FIX = 64'sd1686629713;
   localparam longint ORIGIN_BOUND = 64'sd16384;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   edge_midpoint_bearing_top #(.CORDIC_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_type pending_words[$];
   rsp_type bearing_queue[$];
   int      error_count = 0;
   int      words_sent = 0;
   int      words_checked = 0;
   int      degenerate_seen = 0;
   int      idle_cycles = 0;
   logic    req_fire_q = 1'b0;

   // Rotates (range, 0) by a Q.30 angle; the folding beyond a quarter turn
   // negates the start vector.
   function automatic void rotate_edge(input longint range, input longint ang,
                                       output longint xo, output longint yo);
      longint x, y, z, xs, ys;
      x = range * 64'sd16384;
      y = 0;
      z = ang;
      if (z > HALF_PI_FIX) begin
         z -= PI_FIX;
         x = -x;
      end else if (z < -HALF_PI_FIX) begin
         z += PI_FIX;
         x = -x;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
         end
      end
      xo = x;
      yo = y;
   endfunction

   function automatic longint sum_direction(input longint xi, input longint yi);
      longint x, y, z, xs, ys;
      x = xi; y = yi; z = 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_FIX : -PI_FIX;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
         end else begin
            x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
         end
      end
      return z;
   endfunction

   function automatic rsp_type predict_bearing(input req_type w);
      longint  la, ra, lx, ly, rx, ry, sx, sy, z;
      rsp_type r;
      la = longint'(w.left_angle);
      ra = longint'(w.right_angle);
      rotate_edge(longint'({1'b0, w.left_range}), la * 131072, lx, ly);
      rotate_edge(longint'({1'b0, w.right_range}), ra * 131072, rx, ry);
      sx = lx + rx;
      sy = ly + ry;
      r.degenerate = (w.left_range == w.right_range && w.left_angle == w.right_angle) ||
                     (sx < ORIGIN_BOUND && sx > -ORIGIN_BOUND &&
                      sy < ORIGIN_BOUND && sy > -ORIGIN_BOUND);
      if (r.degenerate) begin
         r.midpoint_angle = w.left_angle;
      end else begin
         z = sum_direction(sx, sy);
         r.midpoint_angle = 16'((z + 65536) >>> 17);
      end
      return r;
   endfunction

   function automatic req_type edge_word(input int la, input int ra,
                                         input int lr, input int rr);
      req_type w;
      w.left_angle = 16'(la);
      w.right_angle = 16'(ra);
      w.left_range = 16'(lr);
      w.right_range = 16'(rr);
      return w;
   endfunction

   // Acceptance on both channels, sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_fire_q <= 1'b0;
      end else begin
         req_fire_q <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            bearing_queue.push_back(predict_bearing(req_data));
            words_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (bearing_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
               error_count++;
            end else begin
               if (rsp_data.midpoint_angle !== bearing_queue[0].midpoint_angle ||
                   rsp_data.degenerate !== bearing_queue[0].degenerate) begin
                  $display("%0t: mismatch, expected angle %0d degen %0b, actual angle %0d degen %0b",
                           $time, bearing_queue[0].midpoint_angle, bearing_queue[0].degenerate,
                           rsp_data.midpoint_angle, rsp_data.degenerate);
                  error_count++;
               end
               if (bearing_queue[0].degenerate) degenerate_seen++;
               void'(bearing_queue.pop_front());
               words_checked++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (pending_words.size() == 0 && bearing_queue.size() == 0)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, bearing_queue.size());
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire_q) void'(pending_words.pop_front());
         if (!req_valid || req_fire_q) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_words.size() > 0 && !(req_fire_q && pending_words.size() == 0)) begin
               req_valid <= 1'b1;
               req_data <= pending_words[0];
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: the stall style is drawn at random from four modes.
   int stall_mode = 0;
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= (stall_phase % 8 < 3);
         default: rsp_stall <= (stall_phase % 64 < 30);
      endcase
   end

   initial begin
      int la, ra;
      // Extremes of every field, folding beyond a quarter turn, and the
      // out-of-range angle codes.
      pending_words.push_back(edge_word(-25736, 25736, 65535, 65535));
      pending_words.push_back(edge_word(25736, -25736, 0, 65535));
      pending_words.push_back(edge_word(-32768, 32767, 65535, 1));
      pending_words.push_back(edge_word(32767, -32768, 1, 65535));
      pending_words.push_back(edge_word(12868, 12869, 1000, 1000));
      pending_words.push_back(edge_word(-12869, -12868, 40000, 300));
      pending_words.push_back(edge_word(20000, 24000, 5000, 6000));
      pending_words.push_back(edge_word(-20000, 20000, 5000, 6000));
      pending_words.push_back(edge_word(0, 0, 1, 2));
      pending_words.push_back(edge_word(0, 0, 65535, 0));
      // Coinciding edges.
      pending_words.push_back(edge_word(1234, 1234, 777, 777));
      pending_words.push_back(edge_word(-32768, -32768, 0, 0));
      pending_words.push_back(edge_word(25736, 25736, 65535, 65535));
      // Midpoint at the origin: both ranges zero, or opposite equal edges.
      pending_words.push_back(edge_word(100, -9000, 0, 0));
      pending_words.push_back(edge_word(0, 25736, 500, 500));
      pending_words.push_back(edge_word(12868, -12868, 65535, 65535));
      pending_words.push_back(edge_word(6434, -19302, 3000, 3000));
      // Obtuse angle at the point with the short range, and two near-equal long ranges.
      pending_words.push_back(edge_word(-3000, 3000, 100, 60000));
      pending_words.push_back(edge_word(3000, -3000, 60000, 100));
      pending_words.push_back(edge_word(-25000, 25000, 65535, 65534));
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         case ($urandom_range(0, 9))
            0: pending_words.push_back(edge_word($urandom, $urandom, $urandom, $urandom));
            1: begin
               la = $urandom_range(0, 51472) - 25736;
               pending_words.push_back(edge_word(la, la, $urandom_range(0, 3),
                                                 $urandom_range(0, 3)));
            end
            2: begin
               la = $urandom_range(0, 51472) - 25736;
               ra = (la > 0) ? la - 25736 : la + 25736;
               pending_words.push_back(edge_word(la, ra, $urandom_range(0, 65535),
                                                 $urandom_range(0, 65535)));
            end
            default: begin
               la = $urandom_range(0, 51472) - 25736;
               ra = la + $urandom_range(0, 4000) - 2000;
               if (ra > 25736) ra = 25736;
               if (ra < -25736) ra = -25736;
               pending_words.push_back(edge_word(la, ra, $urandom_range(0, 65535),
                                                 $urandom_range(0, 65535)));
            end
         endcase
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && bearing_queue.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d edge pairs through the pipeline, %0d results checked, %0d degenerate.",
               words_sent, words_checked, degenerate_seen);
      if (error_count == 0 && bearing_queue.size() == 0 && !rsp_valid) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/emb_pkg.sv
hdl/emb_rot_cell.sv
hdl/emb_vec_cell.sv
hdl/edge_midpoint_bearing_top.sv
hdl/emb_checker.sv
bench/tb.sv
